>>> rtl/core/pidc_pkg.sv
// Package for the positional PID block: register indexes, reset values,
// the command record passed from front to back, and the gain set record.
// No dependencies.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 20;
  localparam int VALUE_W     = 32;
  localparam int ERR_W       = 33;
  localparam int INTEG_W     = 21;
  localparam int DIFF_W      = 34;
  localparam int ACC_W       = 61;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT = 2'd3;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET   = 24'd2490;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET  = 24'd0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET  = 24'd5571;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RESET = 20'd5000;

  localparam logic ACTION_COMPUTE = 1'b0;
  localparam logic ACTION_RESET   = 1'b1;

  typedef struct packed {
    logic                      reset_op;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
  } pidc_cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } pidc_gains_t;

endpackage

>>> rtl/core/pidc_fifo.sv
// Small first-in first-out queue built from a register array.
// Used between front and back and on the result side. No dependencies.
`timescale 1ns / 1ps

module pidc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/pidc_front.sv
// Front end of the PID block: accepts transactions, keeps the error history
// and the clamped integral, and issues one command per transaction.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_front
  import pidc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      action,
  input  logic signed [VALUE_W-1:0] measured,
  input  logic signed [VALUE_W-1:0] setpoint,
  input  logic [LIMIT_W-1:0]        integ_limit,
  output logic                      cmd_valid,
  output pidc_cmd_t                 cmd
);

  logic signed [ERR_W-1:0]   last_error;
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  sum;
  logic signed [DIFF_W-1:0]  lim_pos;
  logic signed [DIFF_W-1:0]  lim_neg;
  logic signed [INTEG_W-1:0] integ_next;

  always_comb begin
    err     = ERR_W'(setpoint) - ERR_W'(measured);
    sum     = DIFF_W'(error_integral) + DIFF_W'(err);
    lim_pos = $signed({{(DIFF_W-LIMIT_W){1'b0}}, integ_limit});
    lim_neg = -lim_pos;
    if (sum > lim_pos) begin
      integ_next = INTEG_W'(lim_pos);
    end else if (sum < lim_neg) begin
      integ_next = INTEG_W'(lim_neg);
    end else begin
      integ_next = INTEG_W'(sum);
    end
  end

  always_comb begin
    cmd_valid = accept;
    if (action == ACTION_RESET) begin
      cmd.reset_op = 1'b1;
      cmd.err      = '0;
      cmd.integ    = '0;
      cmd.diff     = '0;
    end else begin
      cmd.reset_op = 1'b0;
      cmd.err      = err;
      cmd.integ    = integ_next;
      cmd.diff     = DIFF_W'(err) - DIFF_W'(last_error);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_integral <= '0;
    end else if (accept) begin
      if (action == ACTION_RESET) begin
        last_error     <= '0;
        error_integral <= '0;
      end else begin
        last_error     <= err;
        error_integral <= integ_next;
      end
    end
  end

endmodule

>>> rtl/core/pidc_back.sv
// Back end of the PID block: multiplies, sums, truncates toward zero and
// saturates, in a two-stage pipeline. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_back
  import pidc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int OUT_DEPTH      = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_empty,
  input  pidc_cmd_t                         cmd,
  input  pidc_gains_t                       gains,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
  output logic                              cmd_pop,
  output logic                              res_valid,
  output logic signed [VALUE_W-1:0]         res_drive
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1) + 1;
  localparam int Q_W   = ACC_W - GAIN_FRAC_BITS;

  logic                    s1_valid;
  logic signed [ACC_W-1:0] p_term;
  logic signed [ACC_W-1:0] i_term;
  logic signed [ACC_W-1:0] d_term;
  logic                    s2_valid;
  logic signed [ACC_W-1:0] acc;
  logic [CNT_W-1:0]        in_flight;
  logic signed [Q_W-1:0]   q;
  logic                    frac_nz;

  // Issue only when the output queue has a slot for every result in the pipe and for the new one.
  assign in_flight = CNT_W'(out_count) + CNT_W'(s1_valid) + CNT_W'(s2_valid);
  assign cmd_pop   = !cmd_empty && (in_flight < CNT_W'(OUT_DEPTH));

  // Operands are sign-extended to the accumulator width before multiplying so
  // the full product is kept.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.reset_op) begin
        p_term <= '0;
        i_term <= '0;
        d_term <= '0;
      end else begin
        p_term <= ACC_W'($signed({1'b0, gains.prop})) * ACC_W'(cmd.err);
        i_term <= ACC_W'($signed({1'b0, gains.integ})) * ACC_W'(cmd.integ);
        d_term <= ACC_W'($signed({1'b0, gains.deriv})) * ACC_W'(cmd.diff);
      end
    end
    if (s1_valid) begin
      acc <= p_term + i_term + d_term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop;
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    frac_nz = |acc[GAIN_FRAC_BITS-1:0];
    q = Q_W'(acc >>> GAIN_FRAC_BITS) + Q_W'(acc[ACC_W-1] && frac_nz);
    if (q > Q_W'(32'sh7FFF_FFFF)) begin
      res_drive = 32'sh7FFF_FFFF;
    end else if (q < -Q_W'(33'sh0_8000_0000)) begin
      res_drive = 32'sh8000_0000;
    end else begin
      res_drive = VALUE_W'(q);
    end
    res_valid = s2_valid;
  end

endmodule

>>> rtl/core/positional_pid_integral_clamp.sv
// Top level of the positional PID controller with a clamped error integral.
// Holds the configuration registers and joins front, queue and back.
// Depends on pidc_pkg, pidc_fifo, pidc_front and pidc_back.
`timescale 1ns / 1ps

// Positional PID for one wheel. Each input transaction carries an action, a
// measured value and a setpoint; every transaction yields exactly one drive
// result, in order. A compute action forms error = setpoint - measured, adds
// it to an integral clamped to +/- integ_limit, and returns
// (KP*error + KI*integral + KD*(error - last error)) / 2^GAIN_FRAC_BITS,
// truncated toward zero and saturated to signed 32 bits. A reset action
// clears the error history and the integral and returns zero; the gains keep
// their values. The block takes one transaction per clock cycle while full is
// low: the front end forms each command combinationally and registers the
// controller state, and the back end runs the three multiplies and the final
// sum in a two-stage pipeline that issues every cycle unless the command queue
// is empty or no output slot is free. A command queue of QUEUE_DEPTH entries
// lets the front keep accepting while the result side is held, and an output
// queue of OUT_DEPTH entries holds finished results; full rises only once both
// are backed up. The user writes configuration through cfg_wen, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.

module positional_pid_integral_clamp
  import pidc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH    = 4,
  parameter int OUT_DEPTH      = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      action,
  input  logic signed [VALUE_W-1:0] measured,
  input  logic signed [VALUE_W-1:0] setpoint,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [VALUE_W-1:0] drive,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int CMD_W = $bits(pidc_cmd_t);

  pidc_gains_t                          gains;
  logic [LIMIT_W-1:0]                   integ_limit;
  logic                                 accept;
  logic                                 cmd_valid;
  pidc_cmd_t                            cmd_in;
  pidc_cmd_t                            cmd_out;
  logic [CMD_W-1:0]                     cmd_out_bits;
  logic                                 cmd_full;
  logic                                 cmd_empty;
  logic                                 cmd_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]     cmd_count;
  logic                                 res_valid;
  logic signed [VALUE_W-1:0]            res_drive;
  logic [$clog2(OUT_DEPTH+1)-1:0]       out_count;
  logic                                 out_full;
  logic [VALUE_W-1:0]                   drive_bits;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= PROP_GAIN_RESET;
      gains.integ <= INTEG_GAIN_RESET;
      gains.deriv <= DERIV_GAIN_RESET;
      integ_limit <= INTEG_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROP_GAIN:   gains.prop  <= cfg_data;
        REG_INTEG_GAIN:  gains.integ <= cfg_data;
        REG_DERIV_GAIN:  gains.deriv <= cfg_data;
        REG_INTEG_LIMIT: integ_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The input side is full exactly when the command queue is.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  pidc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .measured    (measured),
    .setpoint    (setpoint),
    .integ_limit (integ_limit),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_in)
  );

  pidc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out_bits),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign cmd_out = pidc_cmd_t'(cmd_out_bits);

  pidc_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .OUT_DEPTH      (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .gains     (gains),
    .out_count (out_count),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_drive (res_drive)
  );

  // The back end reserves an output slot before issuing, so a write here
  // always finds room.
  pidc_fifo #(
    .WIDTH (VALUE_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res_drive),
    .rd_en   (pop),
    .rd_data (drive_bits),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign drive = $signed(drive_bits);

  // The command queue depth is visible only as a fill level; a full output
  // queue with an idle pipe means the back end is simply holding.
  logic unused_status;
  assign unused_status = out_full ^ (|cmd_count);

endmodule

>>> rtl/core/pidc_checker.sv
// Port-level checker for the PID block, attached by a bind statement.
// Depends on pidc_pkg and on the top level positional_pid_integral_clamp.
`timescale 1ns / 1ps

module pidc_checker
  import pidc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic signed [VALUE_W-1:0] drive
);

  // Reset leaves both queues drained.
  a_reset_drains: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // A waiting result holds until it is taken.
  a_drive_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(drive)))
    else $error("waiting result changed before it was taken");

  // Full can only rise right after an input transaction was taken.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an input transaction");

  // Empty can only rise right after a result was taken.
  a_empty_cause: assert property (@(posedge clk) disable iff (rst)
    ($rose(empty) && !$past(rst)) |-> $past(pop && !empty))
    else $error("result vanished without being taken");

endmodule

bind positional_pid_integral_clamp pidc_checker u_pidc_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .drive (drive)
);
